[rtl/fdiv_pkg.sv]
// Types and constants shared by the single-precision divider.
package fdiv_pkg;

   typedef struct packed {
      logic [31:0] dividend;
      logic [31:0] divisor;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] quotient;
      logic [2:0]  status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_DIV0    = 3'd1,
      STATUS_DENORM  = 3'd2,
      STATUS_POS_INF = 3'd3,
      STATUS_NEG_INF = 3'd4,
      STATUS_NAN     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      RND_NEAREST = 2'd0,
      RND_POS_INF = 2'd1,
      RND_NEG_INF = 2'd2,
      RND_TRUNC   = 2'd3
   } round_type;

   localparam int unsigned EXP_BIAS = 127;
   localparam logic [7:0]  EXP_SPECIAL = 8'd255;
   localparam int unsigned QUOT_BITS = 26;

endpackage

[rtl/fdiv_mant_div.sv]
// Radix-2 restoring mantissa divider, one quotient bit per cycle.
module fdiv_mant_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [24:0] dividend_mant,
   input  logic [23:0] divisor_mant,
   output logic        done,
   output logic [25:0] quot,
   output logic        sticky
);
   import fdiv_pkg::*;

   logic [24:0] rem_ff, rem_in;
   logic [23:0] dvs_ff;
   logic [25:0] quot_ff, quot_in;
   logic [4:0]  count_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [25:0] trial;
   logic        fits;

   // try a subtract, then shift the partial remainder
   assign trial = {1'b0, rem_ff} - {2'b00, dvs_ff};
   assign fits  = ~trial[25];
   assign rem_in  = fits ? {trial[23:0], 1'b0} : {rem_ff[23:0], 1'b0};
   assign quot_in = {quot_ff[24:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 5'd1;
         if (count_ff == 5'(QUOT_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // dividend is below twice the divisor, so the first bit is the integer bit
         rem_ff  <= dividend_mant;
         dvs_ff  <= divisor_mant;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign done   = done_ff;
   assign quot   = quot_ff;
   assign sticky = |rem_ff;

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_rem_lt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < {dvs_ff, 1'b0})) else $error("remainder too big");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("restart while busy");
`endif

endmodule

[rtl/float32_divider.sv]
// Top level of the single-precision divider with status reporting.
//  channel  direction  handshake        payload
//  req      in         req_valid/stall  dividend, divisor
//  rsp      out        rsp_valid/stall  quotient, status
//  csr      in         APB write/read   rounding_mode at 0
// An operand pair with a normal path goes from acceptance through a setup
// register, the bit-serial mantissa divider and a rounding state to a registered
// result; an exception result is registered on acceptance. Reset is synchronous
// and clears the sequencer and rounding_mode. A stalled result holds and blocks req.
module float32_divider #(
   parameter int unsigned ADDR_WIDTH = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fdiv_pkg::req_payload_type   req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fdiv_pkg::rsp_payload_type   rsp_payload,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import fdiv_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROUND, S_OUT} state_type;

   state_type       state_ff;
   logic [1:0]      mode_ff;
   logic            sign_ff;
   logic signed [9:0] exp_ff;
   logic            start_ff;
   logic [24:0]     ma_ff;
   logic [23:0]     mb_ff;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;

   logic [7:0]  ea, eb;
   logic [23:0] ma, mb;
   logic        div_done, div_sticky;
   logic [25:0] div_quot;
   logic        accept;
   logic [2:0]  early_status;
   logic        early;

   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= RND_NEAREST;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == '0)
         mode_ff <= csr_pwdata[1:0];
   end

   assign ea = req_payload.dividend[30:23];
   assign eb = req_payload.divisor[30:23];
   assign ma = {1'b1, req_payload.dividend[22:0]};
   assign mb = {1'b1, req_payload.divisor[22:0]};
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;

   always_comb begin
      early = 1'b1;
      early_status = STATUS_OK;
      if (req_payload.divisor[30:0] == 31'd0) early_status = STATUS_DIV0;
      else if (ea == 8'd0 || eb == 8'd0) early_status = STATUS_DENORM;
      else if (ea == EXP_SPECIAL)
         early_status = (req_payload.dividend[22:0] != 23'd0) ? STATUS_NAN :
            (req_payload.dividend[31] ? STATUS_NEG_INF : STATUS_POS_INF);
      else if (eb == EXP_SPECIAL)
         early_status = (req_payload.divisor[22:0] != 23'd0) ? STATUS_NAN :
            (req_payload.divisor[31] ? STATUS_NEG_INF : STATUS_POS_INF);
      else early = 1'b0;
   end

   // dividend is pre-shifted left by one when ma < mb, so it stays below 2*mb
   fdiv_mant_div u_div (
      .clock(clock), .reset(reset), .start(start_ff),
      .dividend_mant(ma_ff), .divisor_mant(mb_ff),
      .done(div_done), .quot(div_quot), .sticky(div_sticky)
   );

   logic        g, rb, inc;
   logic [24:0] mant_sum;
   logic [23:0] mant;
   logic signed [9:0] e_fin;
   assign mant = div_quot[25:2];
   assign g  = div_quot[1];
   assign rb = div_quot[0];

   always_comb begin
      case (round_type'(mode_ff))
         RND_NEAREST: inc = g && (rb || div_sticky || mant[0]);
         RND_POS_INF: inc = !sign_ff && (g || rb || div_sticky);
         RND_NEG_INF: inc = sign_ff && (g || rb || div_sticky);
         default:     inc = 1'b0;
      endcase
      mant_sum = {1'b0, mant} + 25'(inc);
      e_fin = exp_ff + 10'(mant_sum[24]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (accept) begin
               sign_ff <= req_payload.dividend[31] ^ req_payload.divisor[31];
               if (early) begin
                  rsp_ff <= '{quotient: 32'd0, status: early_status};
                  rsp_valid_ff <= 1'b1;
               end else begin
                  mb_ff <= mb;
                  if (ma < mb) begin
                     ma_ff <= {ma, 1'b0};
                     exp_ff <= 10'($signed({2'b0, ea})) - 10'($signed({2'b0, eb}))
                        + 10'(EXP_BIAS) - 10'sd1;
                  end else begin
                     ma_ff <= {1'b0, ma};
                     exp_ff <= 10'($signed({2'b0, ea})) - 10'($signed({2'b0, eb}))
                        + 10'(EXP_BIAS);
                  end
                  start_ff <= 1'b1;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: if (div_done) state_ff <= S_ROUND;
            S_ROUND: begin
               if (exp_ff >= 10'sd255)
                  rsp_ff <= '{quotient: 32'd0,
                     status: sign_ff ? STATUS_NEG_INF : STATUS_POS_INF};
               else if (exp_ff <= 10'sd0)
                  rsp_ff <= '{quotient: 32'd0, status: STATUS_DENORM};
               else if (e_fin >= 10'sd255)
                  rsp_ff <= '{quotient: 32'd0,
                     status: sign_ff ? STATUS_NEG_INF : STATUS_POS_INF};
               else
                  rsp_ff <= '{quotient: {sign_ff, e_fin[7:0],
                     mant_sum[24] ? mant_sum[23:1] : mant_sum[22:0]},
                     status: STATUS_OK};
               rsp_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_ok_quot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |-> rsp_ff.quotient == 32'd0)
      else $error("error result with quotient");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> state_ff == S_DIV) else $error("start outside divide");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> !rsp_valid_ff) else $error("result during divide");
`endif

endmodule
